### rtl/mma_pkg.sv
package mma_pkg;

    localparam int unsigned DataWidth  = 32;
    localparam int unsigned ModWidth   = 30;
    localparam int unsigned AsModWidth = 31;
    localparam int unsigned CfgIdxWidth = 2;

    typedef enum logic [1:0] {
        ACT_MONT_MUL = 2'd0,
        ACT_ADD      = 2'd1,
        ACT_SUB      = 2'd2,
        ACT_REDUCE   = 2'd3
    } t_action;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_MODULUS     = 2'd0,
        CFG_NEG_INVERSE = 2'd1,
        CFG_AS_MODULUS  = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [ModWidth-1:0]   modulus;
        logic [DataWidth-1:0]  neg_inverse;
        logic [AsModWidth-1:0] add_sub_modulus;
    } t_cfg;

    // data that rides along the multiply pipeline
    typedef struct packed {
        logic                 is_mul;
        logic [DataWidth-1:0] alt_result;
    } t_side;

endpackage

### rtl/montgomery_modular_alu.sv
// Modular ALU for 32-bit residues: Montgomery multiply, add, subtract, reduce.
// o_done follows an accepted start through the same pipeline registers for every action.
// Throughput: one transaction per cycle; five multiply/add stages are fully pipelined.
// o_busy is high only during reset; the receiver cannot stall, o_done is a one-cycle strobe.
// Synchronous active-low reset clears the pipeline valids and all config registers to 0.
module montgomery_modular_alu (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [1:0]                      i_action,
    input  logic [mma_pkg::DataWidth-1:0]   i_operand_a,
    input  logic [mma_pkg::DataWidth-1:0]   i_operand_b,
    input  logic                            i_cfg_we,
    input  logic [mma_pkg::CfgIdxWidth-1:0] i_cfg_index,
    input  logic [mma_pkg::DataWidth-1:0]   i_cfg_data,
    output logic                            o_done,
    output logic [mma_pkg::DataWidth-1:0]   o_residue
);
    import mma_pkg::*;

    t_cfg                 cfg;
    t_side                side;
    logic [DataWidth-1:0] alt_result;
    logic                 accept;

    assign o_busy = !i_rst_n;
    assign accept = i_start && !o_busy;

    mma_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mma_simple_op u_simple (
        .i_action (i_action),
        .i_a      (i_operand_a),
        .i_b      (i_operand_b),
        .i_cfg    (cfg),
        .o_result (alt_result)
    );

    assign side.is_mul     = (t_action'(i_action) == ACT_MONT_MUL);
    assign side.alt_result = alt_result;

    mma_mont_pipe u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_a      (i_operand_a),
        .i_b      (i_operand_b),
        .i_side   (side),
        .i_cfg    (cfg),
        .o_valid  (o_done),
        .o_result (o_residue)
    );

endmodule

### rtl/mma_cfg_regs.sv
module mma_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mma_pkg::CfgIdxWidth-1:0] i_cfg_index,
    input  logic [mma_pkg::DataWidth-1:0]   i_cfg_data,
    output mma_pkg::t_cfg                   o_cfg
);
    import mma_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODULUS:     r_cfg.modulus         <= i_cfg_data[ModWidth-1:0];
                CFG_NEG_INVERSE: r_cfg.neg_inverse     <= i_cfg_data;
                CFG_AS_MODULUS:  r_cfg.add_sub_modulus <= i_cfg_data[AsModWidth-1:0];
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/mma_simple_op.sv
module mma_simple_op (
    input  logic [1:0]                    i_action,
    input  logic [mma_pkg::DataWidth-1:0] i_a,
    input  logic [mma_pkg::DataWidth-1:0] i_b,
    input  mma_pkg::t_cfg                 i_cfg,
    output logic [mma_pkg::DataWidth-1:0] o_result
);
    import mma_pkg::*;

    logic [DataWidth-1:0] as_mod;
    logic [DataWidth-1:0] mod;
    logic [DataWidth-1:0] sum;
    logic [DataWidth-1:0] diff;
    logic [DataWidth-1:0] red;

    assign as_mod = {1'b0, i_cfg.add_sub_modulus};
    assign mod    = {2'b0, i_cfg.modulus};
    assign sum    = i_a + i_b - as_mod;
    assign diff   = i_a - i_b;
    assign red    = i_a - mod;

    always_comb begin
        case (t_action'(i_action))
            ACT_ADD:    o_result = sum[DataWidth-1] ? sum + as_mod : sum;
            ACT_SUB:    o_result = ($signed(i_b) > $signed(i_a)) ? diff + as_mod : diff;
            ACT_REDUCE: o_result = red[DataWidth-1] ? red + mod : red;
            default:    o_result = '0;
        endcase
    end

endmodule

### rtl/mma_mont_pipe.sv
module mma_mont_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [mma_pkg::DataWidth-1:0] i_a,
    input  logic [mma_pkg::DataWidth-1:0] i_b,
    input  mma_pkg::t_side                i_side,
    input  mma_pkg::t_cfg                 i_cfg,
    output logic                          o_valid,
    output logic [mma_pkg::DataWidth-1:0] o_result
);
    import mma_pkg::*;

    localparam int unsigned ProdWidth = 2 * DataWidth;
    localparam int unsigned UmWidth   = DataWidth + ModWidth;

    logic [4:0] r_valid;
    t_side      r_side [4];

    logic [ProdWidth-1:0] r_t1, r_t2, r_t3;
    logic [DataWidth-1:0] r_u2;
    logic [UmWidth-1:0]   r_p3;
    logic [DataWidth-1:0] r_r4;
    logic [DataWidth-1:0] r_res5;

    logic [ProdWidth-1:0] n_sum4;
    logic [DataWidth-1:0] n_r2_5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    assign n_sum4 = r_t3 + {{(ProdWidth-UmWidth){1'b0}}, r_p3};
    assign n_r2_5 = r_r4 - {2'b0, i_cfg.modulus};

    always_ff @(posedge i_clk) begin
        // stage 1: t = a*b
        r_t1      <= {{DataWidth{1'b0}}, i_a} * {{DataWidth{1'b0}}, i_b};
        r_side[0] <= i_side;
        // stage 2: u = t * neg_inverse mod 2^32
        r_u2      <= r_t1[DataWidth-1:0] * i_cfg.neg_inverse;
        r_t2      <= r_t1;
        r_side[1] <= r_side[0];
        // stage 3: u * modulus
        r_p3      <= {{ModWidth{1'b0}}, r_u2} * {{DataWidth{1'b0}}, i_cfg.modulus};
        r_t3      <= r_t2;
        r_side[2] <= r_side[1];
        // stage 4: high half of t + u*m, carry out dropped
        r_r4      <= n_sum4[ProdWidth-1:DataWidth];
        r_side[3] <= r_side[2];
        // stage 5: unsigned min(r, r - m), or pass the add/sub/reduce result
        if (r_side[3].is_mul) begin
            r_res5 <= (r_r4 < n_r2_5) ? r_r4 : n_r2_5;
        end else begin
            r_res5 <= r_side[3].alt_result;
        end
    end

    assign o_valid  = r_valid[4];
    assign o_result = r_res5;

endmodule

### rtl/mma_checker.sv
module mma_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_done
);

    // busy reflects reset only
    a_busy_reset: assert property (@(posedge i_clk) o_busy == !i_rst_n)
        else $error("busy outside reset");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##5 o_done)
        else $error("transaction produced no result after 5 cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, 5))
        else $error("result without matching transaction");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && !o_busy) |-> ##5 !o_done)
        else $error("result strobe without transaction");

endmodule

bind montgomery_modular_alu mma_checker u_mma_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_done  (o_done)
);
